// ===== sv/crt_pkg.sv =====
// crt_pkg: shared constants for the Garner CRT reconstruction block.
// Configuration register indexes, reset values and fixed field widths.
// No dependencies.
package crt_pkg;

  localparam int unsigned MAX_MODULI_DEF   = 3;
  localparam int unsigned MODULUS_BITS_DEF = 31;
  localparam int unsigned CFG_DATA_W       = 63;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned TARGET_W         = 63;
  localparam int unsigned COEF_W           = 64;
  localparam int unsigned COUNT_W          = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULI_IN_USE  = 3'd0,
    CFG_MODULUS_FIRST  = 3'd1,
    CFG_MODULUS_SECOND = 3'd2,
    CFG_MODULUS_THIRD  = 3'd3,
    CFG_TARGET_MODULUS = 3'd4
  } cfg_idx_e;

  localparam logic [COUNT_W-1:0] RST_MODULI_IN_USE = 2'd3;
  localparam logic [63:0] RST_MODULUS_FIRST  = 64'd469762049;
  localparam logic [63:0] RST_MODULUS_SECOND = 64'd998244353;
  localparam logic [63:0] RST_MODULUS_THIRD  = 64'd1004535809;
  localparam logic [TARGET_W-1:0] RST_TARGET_MODULUS = '0;

endpackage

// ===== sv/crt_mod_cell.sv =====
// crt_mod_cell: one restoring reduction step, one dividend bit per cell.
// Carries the partial remainder, the remaining dividend bits and sideband.
// No dependencies.
module crt_mod_cell #(
  parameter int unsigned DW = 2,
  parameter int unsigned MW = 2,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [MW-1:0] m_i,
  input  logic          valid_i,
  input  logic [MW-1:0] rem_i,
  input  logic [DW-1:0] rest_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [MW-1:0] rem_o,
  output logic [DW-1:0] rest_o,
  output logic [SW-1:0] side_o
);

  logic          valid_q;
  logic [MW-1:0] rem_q, rem_d;
  logic [DW-1:0] rest_q;
  logic [SW-1:0] side_q;
  logic [MW:0]   rr;
  logic          ge;

  always_comb begin
    rr    = {rem_i, rest_i[DW-1]};
    ge    = rr >= {1'b0, m_i};
    rem_d = ge ? MW'(rr - {1'b0, m_i}) : rr[MW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      rest_q <= {rest_i[DW-2:0], 1'b0};
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign rest_o  = rest_q;
  assign side_o  = side_q;

endmodule

// ===== sv/crt_mod_pipe.sv =====
// crt_mod_pipe: row of crt_mod_cell, reduces a DW-bit value by m in DW stages.
// Depends on crt_mod_cell.
module crt_mod_pipe #(
  parameter int unsigned DW = 2,
  parameter int unsigned MW = 2,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [MW-1:0] m_i,
  input  logic          valid_i,
  input  logic [DW-1:0] val_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [MW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  logic          v_c    [DW+1];
  logic [MW-1:0] rem_c  [DW+1];
  logic [DW-1:0] rest_c [DW+1];
  logic [SW-1:0] side_c [DW+1];

  assign v_c[0]    = valid_i;
  assign rem_c[0]  = '0;
  assign rest_c[0] = val_i;
  assign side_c[0] = side_i;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    crt_mod_cell #(.DW(DW), .MW(MW), .SW(SW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .m_i     (m_i),
      .valid_i (v_c[i]),
      .rem_i   (rem_c[i]),
      .rest_i  (rest_c[i]),
      .side_i  (side_c[i]),
      .valid_o (v_c[i+1]),
      .rem_o   (rem_c[i+1]),
      .rest_o  (rest_c[i+1]),
      .side_o  (side_c[i+1])
    );
  end

  assign valid_o = v_c[DW];
  assign rem_o   = rem_c[DW];
  assign side_o  = side_c[DW];

endmodule

// ===== sv/crt_inv_unit.sv =====
// crt_inv_unit: extended Euclid sequencer deriving the two Garner inverses.
// Shares one serial restoring divider and one multiplier over all steps.
// No dependencies.
module crt_inv_unit #(
  parameter int unsigned MW = 31
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [MW-1:0]   m1_i,
  input  logic [MW-1:0]   m2_i,
  input  logic [MW-1:0]   m3_i,
  input  logic [2*MW-1:0] m12_i,
  output logic            busy_o,
  output logic [MW-1:0]   inv2_o,
  output logic [MW-1:0]   inv3_o
);

  localparam int unsigned DW = 2 * MW;
  localparam int unsigned CW = $clog2(DW);
  localparam int unsigned SW = MW + 2;
  localparam int unsigned PW = 2 * MW + 3;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_FIX  = 3'd6;

  logic [2:0]           st_q;
  logic                 sel_q, first_q;
  logic [CW-1:0]        cnt_q;
  logic [DW-1:0]        dd_q, dd_nx;
  logic [MW-1:0]        dv_q, rem_q, rem_nx;
  logic [MW-1:0]        r0_q, r1_q, t_q, q_q;
  logic signed [SW-1:0] s0_q, s1_q;
  logic signed [PW-1:0] prod_q;
  logic [MW-1:0]        inv2_q, inv3_q;
  logic [MW:0]          rr;
  logic                 ge;
  logic [MW-1:0]        mod_sel;
  logic signed [SW-1:0] sm, fx1, fx2;

  always_comb begin
    rr      = {rem_q, dd_q[DW-1]};
    ge      = rr >= {1'b0, dv_q};
    rem_nx  = ge ? MW'(rr - {1'b0, dv_q}) : rr[MW-1:0];
    dd_nx   = {dd_q[DW-2:0], ge};
    mod_sel = sel_q ? m3_i : m2_i;
    sm      = $signed({2'b00, mod_sel});
    if (s0_q >= sm) begin
      fx1 = s0_q - sm;
    end else if (s0_q <= -sm) begin
      fx1 = s0_q + sm;
    end else begin
      fx1 = s0_q;
    end
    fx2 = (fx1 < 0) ? fx1 + sm : fx1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_LOAD;
      sel_q   <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      unique case (st_q)
        ST_LOAD: begin
          cnt_q   <= '0;
          first_q <= 1'b1;
          st_q    <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(DW - 1)) begin
            first_q <= 1'b0;
            st_q    <= first_q ? ST_CHK : ST_MUL;
          end
        end
        ST_CHK: begin
          cnt_q <= '0;
          st_q  <= (r1_q == '0) ? ST_FIX : ST_DIV;
        end
        ST_MUL:  st_q <= ST_UPD;
        ST_UPD:  st_q <= ST_CHK;
        ST_FIX: begin
          sel_q <= 1'b1;
          st_q  <= sel_q ? ST_IDLE : ST_LOAD;
        end
        default: st_q <= ST_IDLE;
      endcase
      if (start_i) begin
        st_q  <= ST_LOAD;
        sel_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_LOAD: begin
        dd_q  <= sel_q ? m12_i : DW'(m1_i);
        dv_q  <= mod_sel;
        rem_q <= '0;
        r1_q  <= mod_sel;
        s0_q  <= SW'(1);
        s1_q  <= '0;
      end
      ST_DIV: begin
        dd_q  <= dd_nx;
        rem_q <= rem_nx;
        if (cnt_q == CW'(DW - 1)) begin
          if (first_q) begin
            r0_q <= rem_nx;
          end else begin
            q_q <= dd_nx[MW-1:0];
            t_q <= rem_nx;
          end
        end
      end
      ST_CHK: begin
        dd_q  <= DW'(r0_q);
        dv_q  <= r1_q;
        rem_q <= '0;
      end
      ST_MUL: prod_q <= PW'($signed({1'b0, q_q})) * PW'(s1_q);
      ST_UPD: begin
        r0_q <= r1_q;
        r1_q <= t_q;
        s0_q <= s1_q;
        s1_q <= SW'(PW'(s0_q) - prod_q);
      end
      ST_FIX: begin
        if (sel_q) begin
          inv3_q <= fx2[MW-1:0];
        end else begin
          inv2_q <= fx2[MW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign busy_o = st_q != ST_IDLE;
  assign inv2_o = inv2_q;
  assign inv3_o = inv3_q;

endmodule

// ===== sv/crt_garner_reconstruct.sv =====
// crt_garner_reconstruct: three-modulus Garner CRT reconstruction, top level.
// Built from rows of single-bit reduction cells; accepts one item per
// cycle while in_stall_o is low. Two-entry output buffer.
// After reset and after every configuration write the inverses are
// re-derived by extended Euclid; input is stalled meanwhile.
module crt_garner_reconstruct
  import crt_pkg::*;
#(
  parameter int unsigned MAX_MODULI   = MAX_MODULI_DEF,
  parameter int unsigned MODULUS_BITS = MODULUS_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [MODULUS_BITS-1:0] residue_a_i,
  input  logic [MODULUS_BITS-1:0] residue_b_i,
  input  logic [MODULUS_BITS-1:0] residue_c_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [COEF_W-1:0] coefficient_o
);

  localparam int unsigned MW = MODULUS_BITS;
  localparam int unsigned VW = 3 * MW;

  function automatic logic [MW-1:0] sub_mod(input logic [MW-1:0] a,
                                            input logic [MW-1:0] b,
                                            input logic [MW-1:0] m);
    logic [MW:0] diff;
    diff = {1'b0, a} - {1'b0, b};
    sub_mod = diff[MW] ? MW'(diff + {1'b0, m}) : diff[MW-1:0];
  endfunction

  // configuration
  logic [COUNT_W-1:0]  cfg_n_q, n_eff;
  logic [MW-1:0]       m1_q, m2_q, m3_q, em1, em2, em3;
  logic [TARGET_W-1:0] target_q;
  logic [2*MW-1:0]     m12_q;
  logic                cfg_hit;

  always_comb begin
    unique case (cfg_index_i)
      CFG_MODULI_IN_USE, CFG_MODULUS_FIRST, CFG_MODULUS_SECOND,
      CFG_MODULUS_THIRD, CFG_TARGET_MODULUS: cfg_hit = cfg_we_i;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_n_q  <= RST_MODULI_IN_USE;
      m1_q     <= MW'(RST_MODULUS_FIRST);
      m2_q     <= MW'(RST_MODULUS_SECOND);
      m3_q     <= MW'(RST_MODULUS_THIRD);
      target_q <= RST_TARGET_MODULUS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODULI_IN_USE:  cfg_n_q  <= cfg_data_i[COUNT_W-1:0];
        CFG_MODULUS_FIRST:  m1_q     <= cfg_data_i[MW-1:0];
        CFG_MODULUS_SECOND: m2_q     <= cfg_data_i[MW-1:0];
        CFG_MODULUS_THIRD:  m3_q     <= cfg_data_i[MW-1:0];
        CFG_TARGET_MODULUS: target_q <= cfg_data_i[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  assign em1   = (m1_q == '0) ? MW'(1) : m1_q;
  assign em2   = (m2_q == '0) ? MW'(1) : m2_q;
  assign em3   = (m3_q == '0) ? MW'(1) : m3_q;
  assign n_eff = (32'(cfg_n_q) > MAX_MODULI) ? COUNT_W'(MAX_MODULI) : cfg_n_q;

  always_ff @(posedge clk_i) begin
    m12_q <= (2*MW)'(em1) * (2*MW)'(em2);
  end

  // inverse derivation
  logic          inv_busy;
  logic [MW-1:0] inv2, inv3;

  crt_inv_unit #(.MW(MW)) u_inv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_hit),
    .m1_i    (em1),
    .m2_i    (em2),
    .m3_i    (em3),
    .m12_i   (m12_q),
    .busy_o  (inv_busy),
    .inv2_o  (inv2),
    .inv3_o  (inv3)
  );

  // flow control
  logic [1:0]        ob_cnt_q;
  logic [COEF_W-1:0] ob0_q, ob1_q;
  logic              en, in_acc;

  assign en         = ob_cnt_q != 2'd2;
  assign in_stall_o = !en || inv_busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  // residue reduction and x1 mod m2
  logic          p1_v, p2_v, p3_v, p4_v;
  logic [MW-1:0] x1_1, b_1, c_1, bp_2, c_2, x1_2, cp_3, x1_3, bp_3;
  logic [MW-1:0] x1m2_4, x1_4, bp_4, cp_4;

  crt_mod_pipe #(.DW(MW), .MW(MW), .SW(2*MW)) u_p1 (
    .clk_i, .rst_ni, .en_i(en), .m_i(em1), .valid_i(in_acc), .val_i(residue_a_i),
    .side_i({residue_b_i, residue_c_i}), .valid_o(p1_v), .rem_o(x1_1),
    .side_o({b_1, c_1})
  );

  crt_mod_pipe #(.DW(MW), .MW(MW), .SW(2*MW)) u_p2 (
    .clk_i, .rst_ni, .en_i(en), .m_i(em2), .valid_i(p1_v), .val_i(b_1),
    .side_i({c_1, x1_1}), .valid_o(p2_v), .rem_o(bp_2), .side_o({c_2, x1_2})
  );

  crt_mod_pipe #(.DW(MW), .MW(MW), .SW(2*MW)) u_p3 (
    .clk_i, .rst_ni, .en_i(en), .m_i(em3), .valid_i(p2_v), .val_i(c_2),
    .side_i({x1_2, bp_2}), .valid_o(p3_v), .rem_o(cp_3), .side_o({x1_3, bp_3})
  );

  crt_mod_pipe #(.DW(MW), .MW(MW), .SW(3*MW)) u_p4 (
    .clk_i, .rst_ni, .en_i(en), .m_i(em2), .valid_i(p3_v), .val_i(x1_3),
    .side_i({x1_3, bp_3, cp_3}), .valid_o(p4_v), .rem_o(x1m2_4),
    .side_o({x1_4, bp_4, cp_4})
  );

  // second digit
  logic            s1_v_q, s2_v_q, s3_v_q, p5_v, p6_v;
  logic [MW-1:0]   s1_d_q, s1_x1_q, s1_c_q, s2_x1_q, s2_c_q;
  logic [2*MW-1:0] s2_prod_q, s3_x2_q;
  logic [MW-1:0]   k2_5, x1_5, c_5, s3_x1_q, s3_c_q;
  logic [MW-1:0]   x2m3_6, x1_6, c_6;
  logic [2*MW-1:0] x2_6;

  crt_mod_pipe #(.DW(2*MW), .MW(MW), .SW(2*MW)) u_p5 (
    .clk_i, .rst_ni, .en_i(en), .m_i(em2), .valid_i(s2_v_q), .val_i(s2_prod_q),
    .side_i({s2_x1_q, s2_c_q}), .valid_o(p5_v), .rem_o(k2_5), .side_o({x1_5, c_5})
  );

  crt_mod_pipe #(.DW(2*MW), .MW(MW), .SW(4*MW)) u_p6 (
    .clk_i, .rst_ni, .en_i(en), .m_i(em3), .valid_i(s3_v_q), .val_i(s3_x2_q),
    .side_i({s3_x1_q, s3_x2_q, s3_c_q}), .valid_o(p6_v), .rem_o(x2m3_6),
    .side_o({x1_6, x2_6, c_6})
  );

  // third digit
  logic            s4_v_q, s5_v_q, s6_v_q, s7_v_q, p7_v, p8_v;
  logic [MW-1:0]   s4_d_q, s4_x1_q, s5_x1_q, s6_x1_q;
  logic [2*MW-1:0] s4_x2_q, s5_prod_q, s5_x2_q, s6_x2_q, s6_lo_q, s6_hi_q;
  logic [MW-1:0]   k3_7, x1_7;
  logic [2*MW-1:0] x2_7;
  logic [VW-1:0]   x3, s7_val_q;
  logic [TARGET_W-1:0] rem_8;
  logic [COEF_W-1:0]   raw_8, fin;

  crt_mod_pipe #(.DW(2*MW), .MW(MW), .SW(3*MW)) u_p7 (
    .clk_i, .rst_ni, .en_i(en), .m_i(em3), .valid_i(s5_v_q), .val_i(s5_prod_q),
    .side_i({s5_x1_q, s5_x2_q}), .valid_o(p7_v), .rem_o(k3_7), .side_o({x1_7, x2_7})
  );

  assign x3 = VW'(s6_x2_q) + VW'(s6_lo_q) + (VW'(s6_hi_q) << MW);

  crt_mod_pipe #(.DW(VW), .MW(TARGET_W), .SW(COEF_W)) u_p8 (
    .clk_i, .rst_ni, .en_i(en), .m_i(target_q), .valid_i(s7_v_q), .val_i(s7_val_q),
    .side_i(COEF_W'(s7_val_q)), .valid_o(p8_v), .rem_o(rem_8), .side_o(raw_8)
  );

  assign fin = (target_q != '0) ? COEF_W'(rem_8) : raw_8;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= p4_v;
      s2_v_q <= s1_v_q;
      s3_v_q <= p5_v;
      s4_v_q <= p6_v;
      s5_v_q <= s4_v_q;
      s6_v_q <= p7_v;
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_d_q    <= sub_mod(bp_4, x1m2_4, em2);
      s1_x1_q   <= x1_4;
      s1_c_q    <= cp_4;
      s2_prod_q <= (2*MW)'(s1_d_q) * (2*MW)'(inv2);
      s2_x1_q   <= s1_x1_q;
      s2_c_q    <= s1_c_q;
      s3_x2_q   <= (2*MW)'(k2_5) * (2*MW)'(em1) + (2*MW)'(x1_5);
      s3_x1_q   <= x1_5;
      s3_c_q    <= c_5;
      s4_d_q    <= sub_mod(c_6, x2m3_6, em3);
      s4_x1_q   <= x1_6;
      s4_x2_q   <= x2_6;
      s5_prod_q <= (2*MW)'(s4_d_q) * (2*MW)'(inv3);
      s5_x1_q   <= s4_x1_q;
      s5_x2_q   <= s4_x2_q;
      s6_lo_q   <= (2*MW)'(k3_7) * (2*MW)'(m12_q[MW-1:0]);
      s6_hi_q   <= (2*MW)'(k3_7) * (2*MW)'(m12_q[2*MW-1:MW]);
      s6_x1_q   <= x1_7;
      s6_x2_q   <= x2_7;
      unique case (n_eff)
        2'd0:    s7_val_q <= '0;
        2'd1:    s7_val_q <= VW'(s6_x1_q);
        2'd2:    s7_val_q <= VW'(s6_x2_q);
        default: s7_val_q <= x3;
      endcase
    end
  end

  // output buffer
  logic push, pop;
  assign push = en && p8_v;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_cnt_q <= 2'd0;
    end else begin
      ob_cnt_q <= ob_cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ob_cnt_q == 2'd2) begin
      if (pop) begin
        ob0_q <= ob1_q;
      end
    end else if (push) begin
      if (ob_cnt_q == 2'd0 || pop) begin
        ob0_q <= fin;
      end else begin
        ob1_q <= fin;
      end
    end
  end

  assign out_valid_o   = ob_cnt_q != 2'd0;
  assign coefficient_o = $signed(ob0_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni) inv_busy |-> in_stall_o)
    else $error("item accepted while inverses are being derived");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_hit |=> inv_busy)
    else $error("configuration write did not restart derivation");

  assert property (@(posedge clk_i) disable iff (!rst_ni) push |=> out_valid_o)
    else $error("finished item lost at output buffer");

endmodule
